FILE: rtl/core/burning_ship_escape_time_assert.svh
// Assertion macros used by the escape-time block's checker.
`ifndef BURNING_SHIP_ESCAPE_TIME_ASSERT_SVH
`define BURNING_SHIP_ESCAPE_TIME_ASSERT_SVH

// Clocked assertion, ignored while reset is held.
`define BSE_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BSE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/bse_pkg.sv
// Shared constants, types and helpers of the escape-time block.
package bse_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int FRAC_BITS_DEF  = 22;

    localparam int STEP_W      = 22;
    localparam int STEP_FRAC   = 24;
    localparam int MODE_W      = 2;
    localparam int LIMIT_W     = 10;
    localparam int COUNT_W     = 10;
    localparam int Z_W         = 32;
    localparam int SAT_IN_W    = 64;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;
    localparam int OUT_TDATA_W = 16;

    localparam logic [MODE_W-1:0]  MODE_RESET  = 2'd0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd100;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 22'd83886;

    typedef enum logic [MODE_W-1:0] {
        MODE_PIXEL = 2'd0,
        MODE_JULIA = 2'd1,
        MODE_PLAIN = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REG_MODE  = 2'd0,
        REG_LIMIT = 2'd1,
        REG_XSTEP = 2'd2,
        REG_YSTEP = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [LIMIT_W-1:0] limit;
        logic [STEP_W-1:0]  x_step;
        logic [STEP_W-1:0]  y_step;
    } cfg_t;

    typedef struct packed {
        logic load_coord;
        logic capture_sq;
        logic step_z;
        logic emit;
    } cmd_t;

    // Clamp a wide signed value into the signed Z_W-bit range.
    function automatic logic signed [Z_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = $signed({{(SAT_IN_W-Z_W+1){1'b0}}, {(Z_W-1){1'b1}}});
        lo = ~hi;
        if (v > hi) begin
            return hi[Z_W-1:0];
        end else if (v < lo) begin
            return lo[Z_W-1:0];
        end
        return v[Z_W-1:0];
    endfunction

endpackage

FILE: rtl/core/bse_regs.sv
// APB configuration registers of the escape-time block.
module bse_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bse_pkg::APB_AW-1:0] paddr,
    input  logic [bse_pkg::APB_DW-1:0] pwdata,
    output logic [bse_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output bse_pkg::cfg_t              cfg
);
    import bse_pkg::*;

    logic [MODE_W-1:0]  mode_reg,  mode_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [STEP_W-1:0]  xstep_reg, xstep_next;
    logic [STEP_W-1:0]  ystep_reg, ystep_next;
    logic               wr_en;
    reg_idx_t           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);

    always_comb begin
        mode_next  = mode_reg;
        limit_next = limit_reg;
        xstep_next = xstep_reg;
        ystep_next = ystep_reg;
        if (wr_en) begin
            case (idx)
                REG_MODE:  mode_next  = pwdata[MODE_W-1:0];
                REG_LIMIT: limit_next = pwdata[LIMIT_W-1:0];
                REG_XSTEP: xstep_next = pwdata[STEP_W-1:0];
                REG_YSTEP: ystep_next = pwdata[STEP_W-1:0];
                default:   mode_next  = mode_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MODE:  prdata = APB_DW'(mode_reg);
            REG_LIMIT: prdata = APB_DW'(limit_reg);
            REG_XSTEP: prdata = APB_DW'(xstep_reg);
            REG_YSTEP: prdata = APB_DW'(ystep_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_RESET;
            limit_reg <= LIMIT_RESET;
            xstep_reg <= STEP_RESET;
            ystep_reg <= STEP_RESET;
        end else begin
            mode_reg  <= mode_next;
            limit_reg <= limit_next;
            xstep_reg <= xstep_next;
            ystep_reg <= ystep_next;
        end
    end

    assign cfg.mode   = mode_reg;
    assign cfg.limit  = limit_reg;
    assign cfg.x_step = xstep_reg;
    assign cfg.y_step = ystep_reg;

endmodule

FILE: rtl/core/bse_datapath.sv
// Fixed-point datapath: pixel mapping, squaring, escape test, iteration count.
module bse_datapath #(
    parameter int COORD_BITS = bse_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = bse_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic [COORD_BITS-1:0]       pixel_x,
    input  logic [COORD_BITS-1:0]       pixel_y,
    input  bse_pkg::cfg_t               cfg,
    input  bse_pkg::cmd_t               cmd,
    output logic                        stop,
    output logic [bse_pkg::COUNT_W-1:0] escape_count
);
    import bse_pkg::*;

    localparam int ProdW  = COORD_BITS + STEP_W;
    localparam int AlignW = ProdW + 6;
    localparam int ShR    = (FRAC_BITS <= STEP_FRAC) ? STEP_FRAC - FRAC_BITS : 0;
    localparam int ShL    = (FRAC_BITS > STEP_FRAC) ? FRAC_BITS - STEP_FRAC : 0;
    localparam int SqW    = 2 * Z_W;
    localparam int CrossW = SqW - 2;
    localparam int ThW    = SqW + 2;

    // 2.25 in the working format
    localparam logic [AlignW-1:0] Offset    = AlignW'(9) << (FRAC_BITS - 2);
    localparam logic [Z_W-1:0]    JuliaC    =
        Z_W'(((64'd285 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [SqW-1:0]    MaxMag    = SqW'((65'd1 << (Z_W - 1)) - 65'd1);
    localparam logic [SqW-1:0]    SatSq     = SqW'(MaxMag * MaxMag);
    localparam logic [SqW-1:0]    FullSq    = SqW'(1) << (SqW - 2);
    // |z|^2 >= 400
    localparam logic [ThW-1:0]    EscThresh = ThW'(25) << (2 * FRAC_BITS + 4);

    logic [ProdW-1:0]         prod_x, prod_y;
    logic [AlignW-1:0]        al_x, al_y;
    logic signed [Z_W-1:0]    cre_init, cim_init;

    logic [Z_W-1:0]           mag_re, mag_im;
    logic [Z_W-2:0]           sat_re, sat_im;
    logic [SqW-1:0]           sq_re_next, sq_im_next;
    logic [CrossW-1:0]        cross_next;

    logic [ThW-1:0]           esc_sum;
    logic [SqW-1:0]           sa2, sb2;
    logic signed [SqW:0]      diff;
    logic signed [SqW:0]      diff_sh;
    logic [CrossW-1:0]        cross_sh;
    logic signed [Z_W-1:0]    nre, nim;
    logic signed [Z_W-1:0]    re_next, im_next;

    logic signed [Z_W-1:0]    cre_reg, cim_reg, re_reg, im_reg;
    logic [SqW-1:0]           sq_re_reg, sq_im_reg;
    logic [CrossW-1:0]        cross_reg;
    logic [COUNT_W-1:0]       count_reg, out_count_reg;

    // pixel -> start point, 24 fraction bits realigned to FRAC_BITS
    always_comb begin
        prod_x   = ProdW'(pixel_x) * ProdW'(cfg.x_step);
        prod_y   = ProdW'(pixel_y) * ProdW'(cfg.y_step);
        al_x     = (AlignW'(prod_x) << ShL) >> ShR;
        al_y     = (AlignW'(prod_y) << ShL) >> ShR;
        cre_init = sat32(SAT_IN_W'($signed(al_x - Offset)));
        cim_init = sat32(SAT_IN_W'($signed(al_y - Offset)));
    end

    // squaring stage: full magnitudes for the escape test, clamped ones for the step
    always_comb begin
        mag_re     = re_reg[Z_W-1] ? Z_W'(-re_reg) : Z_W'(re_reg);
        mag_im     = im_reg[Z_W-1] ? Z_W'(-im_reg) : Z_W'(im_reg);
        sat_re     = mag_re[Z_W-1] ? {(Z_W-1){1'b1}} : mag_re[Z_W-2:0];
        sat_im     = mag_im[Z_W-1] ? {(Z_W-1){1'b1}} : mag_im[Z_W-2:0];
        sq_re_next = SqW'(mag_re) * SqW'(mag_re);
        sq_im_next = SqW'(mag_im) * SqW'(mag_im);
        cross_next = CrossW'(sat_re) * CrossW'(sat_im);
    end

    // test and update stage
    always_comb begin
        esc_sum  = ThW'(sq_re_reg) + ThW'(sq_im_reg);
        stop     = (esc_sum >= EscThresh) || (count_reg >= cfg.limit);

        // only the most negative value squares to FullSq; its clamped square differs
        sa2      = (sq_re_reg == FullSq) ? SatSq : sq_re_reg;
        sb2      = (sq_im_reg == FullSq) ? SatSq : sq_im_reg;
        diff     = $signed({1'b0, sa2}) - $signed({1'b0, sb2});
        diff_sh  = diff >>> FRAC_BITS;
        cross_sh = cross_reg >> (FRAC_BITS - 1);
        nre      = sat32(SAT_IN_W'(diff_sh));
        nim      = sat32($signed(SAT_IN_W'(cross_sh)));

        case (cfg.mode)
            MODE_PIXEL: begin
                re_next = sat32(SAT_IN_W'(nre) + SAT_IN_W'(cre_reg));
                im_next = sat32(SAT_IN_W'(nim) + SAT_IN_W'(cim_reg));
            end
            MODE_JULIA: begin
                re_next = sat32(SAT_IN_W'(nre) + $signed(SAT_IN_W'(JuliaC)));
                im_next = nim;
            end
            default: begin
                re_next = nre;
                im_next = nim;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_coord) begin
            cre_reg   <= cre_init;
            cim_reg   <= cim_init;
            re_reg    <= cre_init;
            im_reg    <= cim_init;
            count_reg <= '0;
        end
        if (cmd.capture_sq) begin
            sq_re_reg <= sq_re_next;
            sq_im_reg <= sq_im_next;
            cross_reg <= cross_next;
        end
        if (cmd.step_z) begin
            re_reg    <= re_next;
            im_reg    <= im_next;
            count_reg <= COUNT_W'(count_reg + 1'b1);
        end
        if (cmd.emit) begin
            out_count_reg <= count_reg;
        end
    end

    assign escape_count = out_count_reg;

endmodule

FILE: rtl/core/bse_ctrl.sv
// Sequencer of the escape-time block: accept, square/test loop, result handoff.
module bse_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  logic          stop,
    output bse_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SQUARE = 4'b0010,
        ST_TEST   = 4'b0100,
        ST_DRAIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        out_free   = !m_tvalid_reg || m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_coord = 1'b1;
                    state_next     = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cmd.capture_sq = 1'b1;
                state_next     = ST_TEST;
            end
            ST_TEST: begin
                if (!stop) begin
                    cmd.step_z = 1'b1;
                    state_next = ST_SQUARE;
                end else if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        m_tvalid_next = cmd.emit || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: rtl/core/burning_ship_escape_time.sv
// Top level of the Burning Ship escape-time block.
//
//  channel   direction  handshake               payload
//  s_*       in         s_tvalid / s_tready     s_tdata: pixel_x, pixel_y
//  m_*       out        m_tvalid / m_tready     m_tdata: escape_count
//  APB       in         psel/penable/pwrite     paddr, pwdata, prdata
//
// One pixel at a time. Each iteration runs a square state, then a test and
// update state; the split follows the squaring multipliers and the
// registered escape test. Synchronous active-low reset clears the
// sequencer and the APB configuration registers.
// A result waiting in the output register does not block the next pixel; only
// a second finished result stalls, in a drain state, until m_tready.
module burning_ship_escape_time #(
    parameter int COORD_BITS = bse_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = bse_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input items
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [COORD_BITS-1:0] pixel_x, [2*COORD_BITS-1:COORD_BITS] pixel_y, zero pad
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    // result items
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [9:0] escape_count, zero pad
    output logic [bse_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [bse_pkg::APB_AW-1:0]             paddr,
    input  logic [bse_pkg::APB_DW-1:0]             pwdata,
    output logic [bse_pkg::APB_DW-1:0]             prdata,
    output logic                                   pready
);
    import bse_pkg::*;

    cfg_t               cfg;
    cmd_t               cmd;
    logic               stop;
    logic [COUNT_W-1:0] escape_count;

    // register file: mode, limit, axis steps
    bse_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer owns both handshakes; datapath only sees commands
    bse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stop     (stop),
        .cmd      (cmd)
    );

    // pixel fields are taken straight off the bus on the accept cycle
    bse_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .pixel_x      (s_tdata[COORD_BITS-1:0]),
        .pixel_y      (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .cfg          (cfg),
        .cmd          (cmd),
        .stop         (stop),
        .escape_count (escape_count)
    );

    assign m_tdata = OUT_TDATA_W'(escape_count);

endmodule

FILE: rtl/core/bse_checker.sv
// Port-level checks of the escape-time block, bound to the top level.
`include "burning_ship_escape_time_assert.svh"

module bse_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bse_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic s_acc;
    logic m_wait;

    assign s_acc  = s_tvalid && s_tready;
    assign m_wait = m_tvalid && !m_tready;

    // reset leaves the block empty and ready
    `BSE_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid && s_tready, "busy after reset")

    // one pixel in flight: busy right after an accept
    `BSE_ASSERT_CLK(a_busy_after_accept, aclk, aresetn, s_acc |=> !s_tready, "ready while busy")

    // a result needs at least the square and test cycles
    `BSE_ASSERT_CLK(a_no_instant_result, aclk, aresetn, s_acc |=> !$rose(m_tvalid), "early result")

    // stalled result holds
    `BSE_ASSERT_CLK(a_out_hold, aclk, aresetn, m_wait |=> m_tvalid && $stable(m_tdata), "not held")

endmodule

bind burning_ship_escape_time bse_checker u_bse_checker (.*);
